[rtl/scfd_pkg.sv]
// Shared constants and types for the serial command frame detector.
// No dependencies; the window, emit, top-level and checker files refer to it by scoped name.
package scfd_pkg;

   localparam int WIN_LEN     = 27;
   localparam int BLOCK_LEN   = 16;
   localparam int BLOCK_START = 10;
   localparam int SUM_POS     = 26;
   localparam int IDX_W       = $clog2(BLOCK_LEN);

   localparam logic [7:0] CHAR_G    = 8'h47;
   localparam logic [7:0] CHAR_I    = 8'h49;
   localparam logic [7:0] CHAR_D    = 8'h44;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_R    = 8'h52;
   localparam logic [7:0] CHAR_C    = 8'h43;
   localparam logic [7:0] CHAR_V    = 8'h56;

   typedef enum logic [1:0] {
      STATUS_GID     = 2'd0,
      STATUS_PAYLOAD = 2'd1,
      STATUS_CKFAIL  = 2'd2
   } status_type;

   typedef logic [7:0] byte_type;
   typedef byte_type block_type [BLOCK_LEN];

   typedef struct packed {
      logic       fire;
      status_type kind;
   } detect_type;

endpackage

[rtl/scfd_req_if.sv]
// Input channel: valid/ready handshake carrying one received serial byte.
// Depends on nothing.
interface scfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/scfd_rsp_if.sv]
// Result channel: valid/ready handshake carrying status, payload byte, index and last.
// Depends on nothing.
interface scfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] payload_byte;
   logic [3:0] byte_index;
   logic       last;

   modport source (output valid, output status, output payload_byte,
                   output byte_index, output last, input ready);
   modport sink   (input valid, input status, input payload_byte,
                   input byte_index, input last, output ready);
endinterface

[rtl/scfd_window.sv]
// Sliding byte window with the GID and +RCV frame tests and the checksum adder tree.
// Depends on scfd_pkg.
module scfd_window (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   output scfd_pkg::detect_type  det,
   output scfd_pkg::block_type   block
);

   scfd_pkg::byte_type window_ff [scfd_pkg::WIN_LEN];
   scfd_pkg::byte_type window_in [scfd_pkg::WIN_LEN];
   scfd_pkg::byte_type shifted   [scfd_pkg::WIN_LEN];
   logic [7:0]         lvl1 [8];
   logic [7:0]         lvl2 [4];
   logic [7:0]         lvl3 [2];
   logic [7:0]         sum;
   logic               gid_hit;
   logic               frame_hit;

   always_comb begin
      for (int i = 0; i < scfd_pkg::WIN_LEN - 1; i++) begin
         shifted[i] = window_ff[i + 1];
      end
      shifted[scfd_pkg::WIN_LEN - 1] = rx_byte;
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         lvl1[i] = shifted[scfd_pkg::BLOCK_START + 2 * i]
                 + shifted[scfd_pkg::BLOCK_START + 2 * i + 1];
      end
      for (int i = 0; i < 4; i++) begin
         lvl2[i] = lvl1[2 * i] + lvl1[2 * i + 1];
      end
      for (int i = 0; i < 2; i++) begin
         lvl3[i] = lvl2[2 * i] + lvl2[2 * i + 1];
      end
      sum = lvl3[0] + lvl3[1];
   end

   assign gid_hit = (shifted[24] == scfd_pkg::CHAR_G) &&
                    (shifted[25] == scfd_pkg::CHAR_I) &&
                    (shifted[26] == scfd_pkg::CHAR_D);

   assign frame_hit = (shifted[0] == scfd_pkg::CHAR_PLUS) &&
                      (shifted[1] == scfd_pkg::CHAR_R) &&
                      (shifted[2] == scfd_pkg::CHAR_C) &&
                      (shifted[3] == scfd_pkg::CHAR_V);

   always_comb begin
      det.fire = accept && (gid_hit || frame_hit);
      if (gid_hit) begin
         det.kind = scfd_pkg::STATUS_GID;
      end else if (sum == shifted[scfd_pkg::SUM_POS]) begin
         det.kind = scfd_pkg::STATUS_PAYLOAD;
      end else begin
         det.kind = scfd_pkg::STATUS_CKFAIL;
      end
      for (int i = 0; i < scfd_pkg::BLOCK_LEN; i++) begin
         block[i] = shifted[scfd_pkg::BLOCK_START + i];
      end
   end

   always_comb begin
      for (int i = 0; i < scfd_pkg::WIN_LEN; i++) begin
         if (!accept) begin
            window_in[i] = window_ff[i];
         end else if (gid_hit || frame_hit) begin
            window_in[i] = '0;
         end else begin
            window_in[i] = shifted[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < scfd_pkg::WIN_LEN; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         window_ff <= window_in;
      end
   end

endmodule

[rtl/scfd_emit.sv]
// Result register and sequencer: holds one result set and plays it out word by word.
// Depends on scfd_pkg.
module scfd_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  scfd_pkg::detect_type  det,
   input  scfd_pkg::block_type   block,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_payload_byte,
   output logic [3:0]            rsp_byte_index,
   output logic                  rsp_last,
   output logic                  can_take
);

   logic                          pend_ff;
   logic                          pend_in;
   scfd_pkg::status_type          kind_ff;
   scfd_pkg::status_type          kind_in;
   logic [scfd_pkg::IDX_W-1:0]    idx_ff;
   logic [scfd_pkg::IDX_W-1:0]    idx_in;
   scfd_pkg::byte_type            data_ff [scfd_pkg::BLOCK_LEN];
   scfd_pkg::byte_type            data_in [scfd_pkg::BLOCK_LEN];
   logic                          is_payload;
   logic                          last_word;
   logic                          take;
   logic                          done;

   assign is_payload = (kind_ff == scfd_pkg::STATUS_PAYLOAD);
   assign last_word  = !is_payload ||
                       (idx_ff == scfd_pkg::IDX_W'(scfd_pkg::BLOCK_LEN - 1));
   assign take       = pend_ff && rsp_ready;
   assign done       = take && last_word;
   assign can_take   = !pend_ff || done;

   assign rsp_valid        = pend_ff;
   assign rsp_status       = kind_ff;
   assign rsp_payload_byte = is_payload ? data_ff[0] : 8'd0;
   assign rsp_byte_index   = is_payload ? 4'(idx_ff) : 4'd0;
   assign rsp_last         = last_word;

   always_comb begin
      pend_in = pend_ff;
      kind_in = kind_ff;
      idx_in  = idx_ff;
      data_in = data_ff;
      if (det.fire) begin
         pend_in = 1'b1;
         kind_in = det.kind;
         idx_in  = '0;
         data_in = block;
      end else if (done) begin
         pend_in = 1'b0;
      end else if (take) begin
         // advance to the next payload word
         idx_in = idx_ff + 1'b1;
         for (int i = 0; i < scfd_pkg::BLOCK_LEN - 1; i++) begin
            data_in[i] = data_ff[i + 1];
         end
         data_in[scfd_pkg::BLOCK_LEN - 1] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         idx_ff  <= idx_in;
      end
      kind_ff <= kind_in;
      data_ff <= data_in;
   end

endmodule

[rtl/serial_command_frame_detector.sv]
// Serial command frame detector top level: window/detect stage feeding the result sequencer.
// Depends on scfd_pkg, scfd_req_if, scfd_rsp_if, scfd_window and scfd_emit.
// First result word is valid in the cycle after the byte that completes a pattern.
// Throughput: one byte per cycle while no result set is held; a payload set occupies the
// result port for 16 words, and a new byte is taken in the cycle its final word leaves.
// Reset: synchronous; clears the window to zeros and drops any held result set.
module serial_command_frame_detector (
   input  logic       clock,
   input  logic       reset,
   scfd_req_if.sink   req_ch,
   scfd_rsp_if.source rsp_ch
);

   scfd_pkg::detect_type det;
   scfd_pkg::block_type  block;
   logic                 can_take;
   logic                 accept;

   assign req_ch.ready = can_take;
   assign accept       = req_ch.valid && can_take;

   scfd_window u_window (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_ch.rx_byte),
      .det     (det),
      .block   (block)
   );

   scfd_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .det              (det),
      .block            (block),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_status       (rsp_ch.status),
      .rsp_payload_byte (rsp_ch.payload_byte),
      .rsp_byte_index   (rsp_ch.byte_index),
      .rsp_last         (rsp_ch.last),
      .can_take         (can_take)
   );

endmodule

[rtl/scfd_checker.sv]
// Port-level checks on the result stream of the frame detector, bound to the top level.
// Depends on scfd_pkg and serial_command_frame_detector.
module scfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_payload_byte,
   input logic [3:0] rsp_byte_index,
   input logic       rsp_last
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_payload_byte) && $stable(rsp_byte_index) && $stable(rsp_last))
      else $error("stalled result word changed");

   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid &&
         rsp_status == scfd_pkg::STATUS_PAYLOAD &&
         rsp_byte_index == $past(rsp_byte_index) + 4'd1)
      else $error("payload run broken");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != scfd_pkg::STATUS_PAYLOAD |->
         rsp_last && rsp_payload_byte == 8'd0 && rsp_byte_index == 4'd0)
      else $error("single result word malformed");

   a_payload_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == scfd_pkg::STATUS_PAYLOAD |->
         rsp_last == (rsp_byte_index == 4'd15))
      else $error("payload last mark misplaced");

endmodule

bind serial_command_frame_detector scfd_checker u_scfd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_payload_byte (rsp_ch.payload_byte),
   .rsp_byte_index   (rsp_ch.byte_index),
   .rsp_last         (rsp_ch.last)
);
